// ===== hdl/jtl_pkg.sv =====
package jtl_pkg;

  // result kinds
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COLON  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_ERROR  = 4'd9;
  localparam logic [3:0] KIND_END    = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd1;
  localparam logic [1:0] ERR_SECOND_DOT = 2'd2;
  localparam logic [1:0] ERR_BAD_BYTE   = 2'd3;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] char_byte;
    logic       has_char;
    logic       token_end;
    logic       number_float;
    logic [1:0] error_code;
    logic       run_last;
  } res_t;

  // one request's results: first always valid, second when pair is set
  typedef struct packed {
    logic pair;
    res_t r0;
    res_t r1;
  } cmd_t;

endpackage

// ===== hdl/jtl_front.sv =====
module jtl_front import jtl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] DIGIT_LO  = 8'd47;
  localparam logic [7:0] DIGIT_HI  = 8'd58;

  logic [1:0] mode_q, mode_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic       dot_seen_q, dot_seen_d;

  logic [1:0] cnt;
  logic       go_idle;
  logic       is_digit;
  logic       is_punct;
  logic [3:0] punct_kind;
  res_t       rr [2];

  function automatic res_t mk(logic [3:0] kind, logic [7:0] ch, logic has,
                              logic tend, logic flt, logic [1:0] err);
    res_t r;
    r.kind         = kind;
    r.char_byte    = ch;
    r.has_char     = has;
    r.token_end    = tend;
    r.number_float = flt;
    r.error_code   = err;
    r.run_last     = 1'b0;
    return r;
  endfunction

  assign is_digit = (data_byte_i > DIGIT_LO) && (data_byte_i < DIGIT_HI);

  always_comb begin
    is_punct   = 1'b1;
    punct_kind = KIND_LBRACE;
    unique case (data_byte_i)
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_LBRACK: punct_kind = KIND_LBRACK;
      CH_RBRACK: punct_kind = KIND_RBRACK;
      CH_COLON:  punct_kind = KIND_COLON;
      CH_COMMA:  punct_kind = KIND_COMMA;
      default:   is_punct   = 1'b0;
    endcase
  end

  always_comb begin
    mode_d       = mode_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    dot_seen_d   = dot_seen_q;
    cnt          = 2'd0;
    go_idle      = 1'b0;
    rr[0]        = '0;
    rr[1]        = '0;

    if (end_of_input_i) begin
      if (mode_q == MODE_STR) begin
        rr[0] = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0, ERR_OPEN_STR);
        cnt   = 2'd1;
      end else if (mode_q == MODE_NUM && held_valid_q) begin
        rr[0] = mk(KIND_NUMBER, held_byte_q, 1'b1, 1'b1, dot_seen_q, ERR_NONE);
        cnt   = 2'd1;
      end
      rr[cnt[0]]   = mk(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
      cnt          = cnt + 2'd1;
      mode_d       = MODE_IDLE;
      held_byte_d  = 8'h00;
      held_valid_d = 1'b0;
      dot_seen_d   = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_STR: begin
          if (data_byte_i == CH_QUOTE) begin
            rr[0] = mk(KIND_STRING, held_valid_q ? held_byte_q : 8'h00, held_valid_q,
                       1'b1, 1'b0, ERR_NONE);
            cnt          = 2'd1;
            mode_d       = MODE_IDLE;
            held_valid_d = 1'b0;
            held_byte_d  = 8'h00;
          end else begin
            if (held_valid_q) begin
              rr[0] = mk(KIND_STRING, held_byte_q, 1'b1, 1'b0, 1'b0, ERR_NONE);
              cnt   = 2'd1;
            end
            held_byte_d  = data_byte_i;
            held_valid_d = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit || (data_byte_i == CH_DOT && !dot_seen_q)) begin
            if (held_valid_q) begin
              rr[0] = mk(KIND_NUMBER, held_byte_q, 1'b1, 1'b0, dot_seen_q, ERR_NONE);
              cnt   = 2'd1;
            end
            if (data_byte_i == CH_DOT) dot_seen_d = 1'b1;
            held_byte_d  = data_byte_i;
            held_valid_d = 1'b1;
          end else if (data_byte_i == CH_DOT) begin
            rr[0]        = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0, ERR_SECOND_DOT);
            cnt          = 2'd1;
            mode_d       = MODE_ERR;
            held_valid_d = 1'b0;
            held_byte_d  = 8'h00;
            dot_seen_d   = 1'b0;
          end else begin
            // number closed by another byte, which is then lexed from idle
            if (held_valid_q) begin
              rr[0] = mk(KIND_NUMBER, held_byte_q, 1'b1, 1'b1, dot_seen_q, ERR_NONE);
              cnt   = 2'd1;
            end
            mode_d       = MODE_IDLE;
            held_valid_d = 1'b0;
            held_byte_d  = 8'h00;
            dot_seen_d   = 1'b0;
            go_idle      = 1'b1;
          end
        end
        MODE_IDLE: go_idle = 1'b1;
        MODE_ERR: ;
      endcase

      if (go_idle) begin
        priority if (is_punct) begin
          rr[cnt[0]] = mk(punct_kind, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
          cnt        = cnt + 2'd1;
        end else if (data_byte_i == CH_QUOTE) begin
          mode_d       = MODE_STR;
          held_valid_d = 1'b0;
          held_byte_d  = 8'h00;
        end else if (is_digit) begin
          mode_d       = MODE_NUM;
          held_byte_d  = data_byte_i;
          held_valid_d = 1'b1;
          dot_seen_d   = 1'b0;
        end else if (data_byte_i == CH_SPACE || data_byte_i == CH_TAB
                     || data_byte_i == CH_NL) begin
          // whitespace skipped
        end else begin
          rr[cnt[0]]   = mk(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0, ERR_BAD_BYTE);
          cnt          = cnt + 2'd1;
          mode_d       = MODE_ERR;
          held_valid_d = 1'b0;
          held_byte_d  = 8'h00;
          dot_seen_d   = 1'b0;
        end
      end
    end

    if (cnt == 2'd2) rr[1].run_last = 1'b1;
    else if (cnt == 2'd1) rr[0].run_last = 1'b1;
  end

  assign cmd_push_o = accept_i && (cnt != 2'd0);
  assign cmd_o.pair = (cnt == 2'd2);
  assign cmd_o.r0   = rr[0];
  assign cmd_o.r1   = rr[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_byte_q  <= 8'h00;
      held_valid_q <= 1'b0;
      dot_seen_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      dot_seen_q   <= dot_seen_d;
    end
  end

endmodule

// ===== hdl/jtl_queue.sv =====
module jtl_queue import jtl_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== hdl/jtl_back.sv =====
module jtl_back import jtl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  logic out_valid_q, out_valid_d;
  logic sec_valid_q, sec_valid_d;
  res_t out_q, out_d;
  res_t sec_q, sec_d;
  logic slot_free;

  assign slot_free = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sec_valid_d = sec_valid_q;
    out_d       = out_q;
    sec_d       = sec_q;
    cmd_pop_o   = 1'b0;
    if (slot_free) begin
      if (sec_valid_q) begin
        out_d       = sec_q;
        out_valid_d = 1'b1;
        sec_valid_d = 1'b0;
      end else if (cmd_valid_i) begin
        out_d       = cmd_i.r0;
        out_valid_d = 1'b1;
        cmd_pop_o   = 1'b1;
        sec_d       = cmd_i.r1;
        sec_valid_d = cmd_i.pair;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_valid_q <= sec_valid_d;
    end
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

endmodule

// ===== hdl/json_token_lexer.sv =====
// channel  | direction | handshake    | payload
// ---------+-----------+--------------+-----------------------------------------------
// input    | in        | push / full  | data_byte_i, end_of_input_i
// result   | out       | empty / pop  | kind_o, char_byte_o, has_char_o, token_end_o,
//          |           |              | number_float_o, error_code_o, run_last_o
//
// one input request is taken per cycle while full is low; the lexer state advances
// at that edge, its results enter the command queue, and the first one goes on from
// the queue head into the result register when nothing is ahead of it
// a request with two results holds the result register for both of them in turn; with
// one-result requests right behind it the two-entry command queue fills and full
// rises for one cycle; reset clears lexer state, queue and result register
// stalls on pop back up through the result register and queue to full
module json_token_lexer import jtl_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input side
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [3:0] kind_o,
  output logic [7:0] char_byte_o,
  output logic       has_char_o,
  output logic       token_end_o,
  output logic       number_float_o,
  output logic [1:0] error_code_o,
  output logic       run_last_o
);

  logic accept;
  logic cmd_push;
  cmd_t cmd_in;
  logic q_empty;
  cmd_t q_head;
  logic q_pop;
  res_t res;

  // a request is taken whenever the queue has room
  assign accept = push && !full;

  // front: classifies each byte, tracks string/number/error mode and the held byte,
  // and builds the zero, one or two results that the byte causes
  jtl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  // short queue decouples the front from result-side stalls
  jtl_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_head)
  );

  // back: splits a two-result entry into single results in a registered output
  jtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign kind_o         = res.kind;
  assign char_byte_o    = res.char_byte;
  assign has_char_o     = res.has_char;
  assign token_end_o    = res.token_end;
  assign number_float_o = res.number_float;
  assign error_code_o   = res.error_code;
  assign run_last_o     = res.run_last;

  // error code is set exactly on error results
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((error_code_o != ERR_NONE) == (kind_o == KIND_ERROR)))
    else $error("error code and kind disagree");

  // only string and number results carry a content byte
  a_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_char_o) |-> (kind_o == KIND_STRING || kind_o == KIND_NUMBER))
    else $error("content byte on a non-content result");

  // float flag only on number results
  a_float: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && number_float_o) |-> (kind_o == KIND_NUMBER))
    else $error("float flag on a non-number result");

  // the end marker always closes its request and its token
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_END) |-> (run_last_o && token_end_o))
    else $error("end result not last of its request");

endmodule
